FILE: rtl/core/kvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvs_pkg
// Shared sizes, operation codes and sequencer states of the key/value store.
// ----------------------------------------------------------------------------
package kvs_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int WORD_W  = KEY_W + VAL_W;

  localparam logic [1:0] OP_SAVE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [VAL_W-1:0] MISS_WORD = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } kvs_state_t;

endpackage

FILE: rtl/core/kvs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kvs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/key_value_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_store_core
// Fully associative key/value table searched by a sequential scan.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis: tuser carries the operation (save, read,
// clear), tdata the key and the data word. Each item yields one result item
// on m_axis: tdata is the value found (all ones on a miss or for any other
// operation), tuser holds the hit and table-full flags.
// Pairs live in one RAM, filled from slot 0 upward; slots below the fill
// count are valid, so a clear only zeroes the count.
// Save and read scan the used slots one per cycle through the RAM's single
// read port and stop at the first match, then pass to the result state;
// clear and the unused code go from idle straight to the result state,
// which loads the output register once it is free. One item is worked on
// at a time; s_axis_tready is high only while the sequencer is idle, which
// it returns to as the result is loaded, so no new item is taken before the
// last one's result is loaded.
// Results sit in an output register; a new item may be accepted while it
// waits, but its own result is held back until the receiver takes the old one.
// Reset empties the table and drops any pending result.
// ----------------------------------------------------------------------------
module key_value_store_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] lookup_key, [63:32] data_word
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] read_word
  output logic [1:0]  m_axis_tuser    // [0] hit, [1] table_full
);
  import kvs_pkg::*;

  kvs_state_t        state, state_next;
  logic [1:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  data_r;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  issue_idx;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic [VAL_W-1:0]  res_word;
  logic              res_hit;
  logic              res_full;

  logic              in_fire;
  logic              key_match;
  logic              more;
  logic              scan_done;
  logic              resp_go;
  logic              has_room;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  // RAM word: {value, key}
  kvs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign key_match = pend && (rd_data[KEY_W-1:0] == key_r);
  assign more      = issue_idx < fill_count;
  assign scan_done = key_match || (!pend && !more);
  assign resp_go   = !m_axis_tvalid || m_axis_tready;
  assign has_room  = fill_count < CNT_W'(ENTRIES);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (s_axis_tuser == OP_SAVE || s_axis_tuser == OP_READ) ?
                       ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (resp_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    rd_addr       = issue_idx[IDX_W-1:0];
    wr_addr       = key_match ? pend_idx : fill_count[IDX_W-1:0];
    wr_data       = {data_r, key_r};
    case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_SCAN: begin
        rd_en = more && !key_match;
        wr_en = scan_done && (op_r == OP_SAVE) && (key_match || has_room);
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill_count    <= '0;
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      // in RESP the output register is reloaded below instead
      if (m_axis_tvalid && m_axis_tready && state != ST_RESP) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            op_r      <= s_axis_tuser;
            key_r     <= s_axis_tdata[KEY_W-1:0];
            data_r    <= s_axis_tdata[WORD_W-1:KEY_W];
            issue_idx <= '0;
            pend      <= 1'b0;
            res_word  <= MISS_WORD;
            res_hit   <= 1'b0;
            res_full  <= 1'b0;
            if (s_axis_tuser == OP_CLEAR) begin
              fill_count <= '0;
            end
          end
        end
        ST_SCAN: begin
          pend     <= rd_en;
          pend_idx <= issue_idx[IDX_W-1:0];
          if (rd_en) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (scan_done) begin
            if (key_match) begin
              res_hit <= 1'b1;
              if (op_r == OP_READ) begin
                res_word <= rd_data[WORD_W-1:KEY_W];
              end
            end else if (op_r == OP_SAVE) begin
              if (has_room) begin
                fill_count <= fill_count + CNT_W'(1);
              end else begin
                res_full <= 1'b1;
              end
            end
          end
        end
        ST_RESP: begin
          if (resp_go) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_word;
            m_axis_tuser  <= {res_full, res_hit};
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(ENTRIES))
    else $error("fill count beyond table size");

  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_SCAN && op_r == OP_SAVE))
    else $error("table write outside a save scan");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("ready right after an accepted item");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("hit and table_full both set");

endmodule
